[hdl/bwfa_pkg.sv]
// Package for the best/worst fit allocator: payload structs, status codes
// and sequencer states. No dependencies.
package bwfa_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NO_ADDR  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic CFG_FIT_MODE  = 1'b0;
    localparam logic CFG_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [16:0] request_size;
        logic [15:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_address;
    } t_out_item;

    typedef struct packed {
        logic        index;
        logic [16:0] data;
    } t_cfg_item;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_APPLY = 2'd2,
        S_DONE  = 2'd3
    } t_state;

endpackage

[hdl/bwfa_cell.sv]
// One table slot of the allocator: valid, start and size, plus a search
// stage that passes the running best candidate to its neighbor each cycle.
// Depends on bwfa_pkg.
module bwfa_cell
    import bwfa_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int IDX_BITS  = 4,
    parameter logic [IDX_BITS-1:0] MY_IDX = '0,
    parameter logic INIT_VALID = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Table write from the controller.
    input  logic                 i_wr,
    input  logic                 i_wr_valid,
    input  logic [ADDR_BITS-1:0] i_wr_start,
    input  logic [ADDR_BITS:0]   i_wr_size,
    // Search chain: candidate from the upstream neighbor.
    input  logic                 i_mode_addr,
    input  logic                 i_fit_mode,
    input  logic [ADDR_BITS:0]   i_req,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic                 i_c_hit,
    input  logic [IDX_BITS-1:0]  i_c_idx,
    input  logic [ADDR_BITS:0]   i_c_size,
    input  logic                 i_c_open,
    input  logic [IDX_BITS-1:0]  i_c_open_idx,
    output logic                 o_c_hit,
    output logic [IDX_BITS-1:0]  o_c_idx,
    output logic [ADDR_BITS:0]   o_c_size,
    output logic                 o_c_open,
    output logic [IDX_BITS-1:0]  o_c_open_idx,
    output logic [ADDR_BITS-1:0] o_start,
    output logic [ADDR_BITS:0]   o_size
);

    logic                 r_valid;
    logic [ADDR_BITS-1:0] r_start;
    logic [ADDR_BITS:0]   r_size;
    logic                 w_take;

    // Slot storage. Start and size are loaded by the table clear held during reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= INIT_VALID;
        end else if (i_wr) begin
            r_valid <= i_wr_valid;
        end
        if (i_wr) begin
            r_start <= i_wr_start;
            r_size  <= i_wr_size;
        end
    end

    // Compare this slot against the upstream candidate; lower slot wins ties.
    always_comb begin
        w_take = 1'b0;
        if (r_valid) begin
            if (i_mode_addr) begin
                w_take = !i_c_hit && (r_start == i_addr);
            end else if (r_size >= i_req) begin
                w_take = !i_c_hit ||
                         (!i_fit_mode && r_size < i_c_size) ||
                         (i_fit_mode && r_size > i_c_size);
            end
        end
    end

    // Registered hand-off to the next cell.
    always_ff @(posedge i_clk) begin
        o_c_hit      <= i_c_hit | w_take;
        o_c_idx      <= w_take ? MY_IDX : i_c_idx;
        o_c_size     <= w_take ? r_size : i_c_size;
        o_c_open     <= i_c_open | !r_valid;
        o_c_open_idx <= (!i_c_open && !r_valid) ? MY_IDX : i_c_open_idx;
    end

    assign o_start = r_start;
    assign o_size  = r_size;

endmodule

[hdl/bwfa_table.sv]
// A chain of bwfa_cell slots forming one block table. The search result is registered
// in every cell and leaves the last cell. Depends on bwfa_pkg, bwfa_cell.
module bwfa_table
    import bwfa_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int ENTRIES   = 16,
    parameter int IDX_BITS  = 4,
    parameter logic INIT_SLOT0 = 1'b1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [IDX_BITS-1:0]  i_wr_idx,
    input  logic                 i_wr_valid,
    input  logic [ADDR_BITS-1:0] i_wr_start,
    input  logic [ADDR_BITS:0]   i_wr_size,
    input  logic                 i_clear,
    input  logic [ADDR_BITS:0]   i_init_size,
    input  logic                 i_mode_addr,
    input  logic                 i_fit_mode,
    input  logic [ADDR_BITS:0]   i_req,
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic                 o_hit,
    output logic [IDX_BITS-1:0]  o_idx,
    output logic                 o_open,
    output logic [IDX_BITS-1:0]  o_open_idx,
    output logic [ADDR_BITS-1:0] o_sel_start,
    output logic [ADDR_BITS:0]   o_sel_size
);

    logic                 c_hit      [ENTRIES+1];
    logic [IDX_BITS-1:0]  c_idx      [ENTRIES+1];
    logic [ADDR_BITS:0]   c_size     [ENTRIES+1];
    logic                 c_open     [ENTRIES+1];
    logic [IDX_BITS-1:0]  c_open_idx [ENTRIES+1];
    logic [ADDR_BITS-1:0] st         [ENTRIES];
    logic [ADDR_BITS:0]   sz         [ENTRIES];

    assign c_hit[0]      = 1'b0;
    assign c_idx[0]      = '0;
    assign c_size[0]     = '0;
    assign c_open[0]     = 1'b0;
    assign c_open_idx[0] = '0;

    // One cell per slot; a clear leaves slot 0 holding the pool when INIT_SLOT0
    // is set and every other slot invalid.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic                 w_wr;
        logic                 w_v;
        logic [ADDR_BITS-1:0] w_s;
        logic [ADDR_BITS:0]   w_z;
        assign w_wr = i_clear || (i_wr && i_wr_idx == IDX_BITS'(g));
        assign w_v  = i_clear ? (INIT_SLOT0 && (g == 0)) : i_wr_valid;
        assign w_s  = i_clear ? '0 : i_wr_start;
        assign w_z  = i_clear ? i_init_size : i_wr_size;
        bwfa_cell #(
            .ADDR_BITS  (ADDR_BITS),
            .IDX_BITS   (IDX_BITS),
            .MY_IDX     (IDX_BITS'(g)),
            .INIT_VALID (INIT_SLOT0 && (g == 0))
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr         (w_wr),
            .i_wr_valid   (w_v),
            .i_wr_start   (w_s),
            .i_wr_size    (w_z),
            .i_mode_addr  (i_mode_addr),
            .i_fit_mode   (i_fit_mode),
            .i_req        (i_req),
            .i_addr       (i_addr),
            .i_c_hit      (c_hit[g]),
            .i_c_idx      (c_idx[g]),
            .i_c_size     (c_size[g]),
            .i_c_open     (c_open[g]),
            .i_c_open_idx (c_open_idx[g]),
            .o_c_hit      (c_hit[g+1]),
            .o_c_idx      (c_idx[g+1]),
            .o_c_size     (c_size[g+1]),
            .o_c_open     (c_open[g+1]),
            .o_c_open_idx (c_open_idx[g+1]),
            .o_start      (st[g]),
            .o_size       (sz[g])
        );
    end

    assign o_hit      = c_hit[ENTRIES];
    assign o_idx      = c_idx[ENTRIES];
    assign o_open     = c_open[ENTRIES];
    assign o_open_idx = c_open_idx[ENTRIES];
    // Read back the chosen slot's contents.
    assign o_sel_start = st[o_idx];
    assign o_sel_size  = sz[o_idx];

endmodule

[hdl/best_worst_fit_allocator_unit.sv]
// Best/worst fit allocator: free and used block tables, each a chain of slot
// cells, driven by a small sequencer. Depends on bwfa_pkg and bwfa_table.
//
// Each request launches a search down both tables at once; the candidate
// ripples one slot per cycle, and the block takes one request at a time.
// The result is held in an output register; the next request is accepted no
// earlier than the cycle in which that result is taken. A pool_size write
// reloads the tables, and reset loads them the same way.
module best_worst_fit_allocator_unit
    import bwfa_pkg::*;
#(
    parameter int FREE_ENTRIES = 16,
    parameter int USED_ENTRIES = 16,
    parameter int ADDR_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_cfg_item i_cfg_data
);

    localparam int FB = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int UB = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int SCAN = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
    localparam int CB = $clog2(SCAN + 1);
    localparam logic [ADDR_BITS:0] POOL_MAX = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [ADDR_BITS:0] POOL_RST =
        (ADDR_BITS >= 16) ? (ADDR_BITS+1)'(17'h10000) : POOL_MAX;

    t_state               r_state, n_state;
    logic [CB-1:0]        r_cnt;
    logic                 r_fit_mode;
    logic [ADDR_BITS:0]   r_pool;
    logic                 r_kind;
    logic [ADDR_BITS:0]   r_req;
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_out_valid;
    t_out_item            r_out;
    logic                 w_clear;
    logic [ADDR_BITS:0]   w_pool_in;
    logic [16:0]          w_cfg_pool;
    logic [ADDR_BITS:0]   w_init_size;

    // Free table outputs and writes.
    logic f_hit, f_open, f_wr, f_wr_v;
    logic [FB-1:0] f_idx, f_open_idx, f_wr_idx;
    logic [ADDR_BITS-1:0] f_sel_start, f_wr_start;
    logic [ADDR_BITS:0] f_sel_size, f_wr_size;
    // Used table outputs and writes.
    logic u_hit, u_open, u_wr, u_wr_v;
    logic [UB-1:0] u_idx, u_open_idx, u_wr_idx;
    logic [ADDR_BITS-1:0] u_sel_start, u_wr_start;
    logic [ADDR_BITS:0] u_sel_size, u_wr_size;
    t_out_item w_res;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !(i_cfg_valid) && !r_out_valid
                         || (r_state == S_IDLE) && !i_cfg_valid && i_out_ready;
    // Reset and a pool_size write both reload the tables.
    assign w_clear     = !i_rst_n ||
                         (i_cfg_valid && o_cfg_ready && (i_cfg_data.index == CFG_POOL_SIZE));
    assign w_init_size = !i_rst_n ? POOL_RST : (w_clear ? w_pool_in : r_pool);

    // Saturate pool size to the address space.
    always_comb begin
        w_cfg_pool = i_cfg_data.data;
        if (ADDR_BITS >= 17) begin
            w_pool_in = (ADDR_BITS+1)'(w_cfg_pool);
        end else if (w_cfg_pool > 17'(POOL_MAX)) begin
            w_pool_in = POOL_MAX;
        end else begin
            w_pool_in = (ADDR_BITS+1)'(w_cfg_pool);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= 1'b0;
            r_pool     <= POOL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_data.index == CFG_FIT_MODE) r_fit_mode <= i_cfg_data.data[0];
            else r_pool <= w_pool_in;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid && o_in_ready) n_state = S_SCAN;
            S_SCAN:  if (r_cnt == CB'(SCAN)) n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Decision from the search results.
    always_comb begin
        w_res = '0;
        f_wr = 1'b0; f_wr_idx = f_idx; f_wr_v = 1'b0;
        f_wr_start = f_sel_start; f_wr_size = f_sel_size;
        u_wr = 1'b0; u_wr_idx = u_open_idx; u_wr_v = 1'b1;
        u_wr_start = f_sel_start; u_wr_size = r_req;
        if (r_kind == KIND_ALLOC) begin
            if (r_req == '0 || !f_hit) begin
                w_res.status = ST_NO_FIT;
            end else if (!u_open) begin
                w_res.status = ST_FULL;
            end else begin
                w_res.status = ST_OK;
                w_res.granted_address = 16'(f_sel_start);
                u_wr = 1'b1;
                f_wr = 1'b1;
                if (f_sel_size == r_req) begin
                    f_wr_v = 1'b0;
                end else begin
                    f_wr_v     = 1'b1;
                    f_wr_start = f_sel_start + ADDR_BITS'(r_req);
                    f_wr_size  = f_sel_size - r_req;
                end
            end
        end else begin
            if (!u_hit) begin
                w_res.status = ST_NO_ADDR;
            end else if (!f_open) begin
                w_res.status = ST_FULL;
            end else begin
                w_res.status = ST_OK;
                f_wr = 1'b1; f_wr_idx = f_open_idx; f_wr_v = 1'b1;
                f_wr_start = u_sel_start; f_wr_size = u_sel_size;
                u_wr = 1'b1; u_wr_idx = u_idx; u_wr_v = 1'b0;
            end
        end
        if (r_state != S_APPLY) begin
            f_wr = 1'b0;
            u_wr = 1'b0;
        end
    end

    // Sequencer, request capture and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == S_SCAN) ? r_cnt + 1'b1 : '0;
            if (r_state == S_APPLY) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_in_data.kind;
            r_req  <= (ADDR_BITS+1)'(i_in_data.request_size);
            r_addr <= ADDR_BITS'(i_in_data.block_address);
        end
        if (r_state == S_APPLY) r_out <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bwfa_table #(
        .ADDR_BITS  (ADDR_BITS),
        .ENTRIES    (FREE_ENTRIES),
        .IDX_BITS   (FB),
        .INIT_SLOT0 (1'b1)
    ) u_free (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (f_wr),
        .i_wr_idx    (f_wr_idx),
        .i_wr_valid  (f_wr_v),
        .i_wr_start  (f_wr_start),
        .i_wr_size   (f_wr_size),
        .i_clear     (w_clear),
        .i_init_size (w_init_size),
        .i_mode_addr (1'b0),
        .i_fit_mode  (r_fit_mode),
        .i_req       (r_req),
        .i_addr      (r_addr),
        .o_hit       (f_hit),
        .o_idx       (f_idx),
        .o_open      (f_open),
        .o_open_idx  (f_open_idx),
        .o_sel_start (f_sel_start),
        .o_sel_size  (f_sel_size)
    );

    bwfa_table #(
        .ADDR_BITS  (ADDR_BITS),
        .ENTRIES    (USED_ENTRIES),
        .IDX_BITS   (UB),
        .INIT_SLOT0 (1'b0)
    ) u_used (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (u_wr),
        .i_wr_idx    (u_wr_idx),
        .i_wr_valid  (u_wr_v),
        .i_wr_start  (u_wr_start),
        .i_wr_size   (u_wr_size),
        .i_clear     (w_clear),
        .i_init_size ('0),
        .i_mode_addr (1'b1),
        .i_fit_mode  (r_fit_mode),
        .i_req       (r_req),
        .i_addr      (r_addr),
        .o_hit       (u_hit),
        .o_idx       (u_idx),
        .o_open      (u_open),
        .o_open_idx  (u_open_idx),
        .o_sel_start (u_sel_start),
        .o_sel_size  (u_sel_size)
    );

endmodule

[tb/tb_alloc_pkg.sv]
// Allocator scoreboard: a predictor of the free and used block tables and a
// store of expected responses. Depends on bwfa_pkg.
package tb_alloc_pkg;
    import bwfa_pkg::*;

    localparam int N_FREE = 16;
    localparam int N_USED = 16;
    localparam int POOL_LIMIT = 65536;

    class alloc_scoreboard;
        bit          fit_largest;
        int          pool_bytes;
        bit          free_vld [N_FREE];
        int          free_start [N_FREE];
        int          free_size [N_FREE];
        bit          used_vld [N_USED];
        int          used_start [N_USED];
        int          used_size [N_USED];
        t_out_item   pending_responses [$];
        int          mismatches;
        int          responses_seen;

        function new();
            fit_largest = 1'b0;
            mismatches = 0;
            responses_seen = 0;
            load_pool(POOL_LIMIT);
        endfunction

        // A pool write saturates the size and leaves one free block at offset 0.
        function void load_pool(int bytes);
            pool_bytes = (bytes > POOL_LIMIT) ? POOL_LIMIT : bytes;
            foreach (free_vld[i]) free_vld[i] = 1'b0;
            foreach (used_vld[i]) used_vld[i] = 1'b0;
            free_vld[0] = 1'b1;
            free_start[0] = 0;
            free_size[0] = pool_bytes;
        endfunction

        function void note_register(logic index, logic [16:0] data);
            if (index == CFG_FIT_MODE) begin
                fit_largest = data[0];
            end else begin
                load_pool(int'(data));
            end
        endfunction

        // Pick the start of some granted block, or -1 when none is out.
        function int granted_start();
            int starts [$];
            foreach (used_vld[i]) if (used_vld[i]) starts.push_back(used_start[i]);
            if (starts.size() == 0) return -1;
            return starts[$urandom_range(0, starts.size() - 1)];
        endfunction

        // Apply one accepted request to the tables and queue its response.
        function void note_request(t_in_item req);
            t_out_item resp;
            int pick;
            int slot;
            int want;
            pick = -1;
            slot = -1;
            want = int'(req.request_size);
            resp.status = ST_OK;
            resp.granted_address = '0;
            if (req.kind == KIND_ALLOC) begin
                if (want == 0) begin
                    resp.status = ST_NO_FIT;
                end else begin
                    // Ties keep the lowest slot, so only a strict win replaces.
                    for (int i = 0; i < N_FREE; i++) begin
                        if (free_vld[i] && free_size[i] >= want) begin
                            if (pick < 0 ||
                                (!fit_largest && free_size[i] < free_size[pick]) ||
                                (fit_largest && free_size[i] > free_size[pick]))
                                pick = i;
                        end
                    end
                    for (int i = N_USED - 1; i >= 0; i--) if (!used_vld[i]) slot = i;
                    if (pick < 0) begin
                        resp.status = ST_NO_FIT;
                    end else if (slot < 0) begin
                        resp.status = ST_FULL;
                    end else begin
                        used_vld[slot] = 1'b1;
                        used_start[slot] = free_start[pick];
                        used_size[slot] = want;
                        resp.granted_address = free_start[pick][15:0];
                        if (free_size[pick] == want) begin
                            free_vld[pick] = 1'b0;
                        end else begin
                            free_start[pick] += want;
                            free_size[pick] -= want;
                        end
                    end
                end
            end else begin
                for (int i = N_USED - 1; i >= 0; i--)
                    if (used_vld[i] && used_start[i] == int'(req.block_address)) pick = i;
                for (int i = N_FREE - 1; i >= 0; i--) if (!free_vld[i]) slot = i;
                if (pick < 0) begin
                    resp.status = ST_NO_ADDR;
                end else if (slot < 0) begin
                    resp.status = ST_FULL;
                end else begin
                    free_vld[slot] = 1'b1;
                    free_start[slot] = used_start[pick];
                    free_size[slot] = used_size[pick];
                    used_vld[pick] = 1'b0;
                end
            end
            pending_responses.push_back(resp);
        endfunction

        // Compare one response beat with the oldest expectation.
        function void check_response(t_out_item got);
            t_out_item want;
            responses_seen++;
            if (pending_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response status=%0d addr=%0d",
                             got.status, got.granted_address);
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status ||
                got.granted_address !== want.granted_address) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d expected status=%0d addr=%0d, got status=%0d addr=%0d",
                             responses_seen, want.status, want.granted_address,
                             got.status, got.granted_address);
            end
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
// Top-level testbench for best_worst_fit_allocator_unit: drives requests and
// register writes, checks responses. Depends on bwfa_pkg and tb_alloc_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bwfa_pkg::*;
    import tb_alloc_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    t_cfg_item i_cfg_data;

    alloc_scoreboard tables = new();
    bit  req_valid_held;
    bit  sender_quiet;
    int  rx_wait;
    int  rx_cycles;

    best_worst_fit_allocator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response side: check every beat, stall at random, and once hold off for
    // a long stretch so that the block backs up into its request channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait <= 0;
            rx_cycles <= 0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                tables.check_response(o_out_data);
                if (tables.responses_seen == 400) begin
                    rx_wait <= 300;
                end else if (((rx_cycles / 2000) % 3) == 0) begin
                    rx_wait <= 0;
                end else begin
                    rx_wait <= $urandom_range(0, 7);
                end
                i_out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one request beat after a random gap (none while the sender is quiet) and wait for its acceptance.
    task automatic send_request(t_in_item req);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0 && req_valid_held) begin
            i_in_valid <= 1'b0;
            req_valid_held = 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= req;
        req_valid_held = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        tables.note_request(req);
    endtask

    // Let the block drain, then allow its search to finish before idling.
    task automatic drain_responses();
        if (req_valid_held) begin
            i_in_valid <= 1'b0;
            req_valid_held = 1'b0;
        end
        while (tables.pending_responses.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_register(logic index, logic [16:0] data);
        drain_responses();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= '{index: index, data: data};
        do @(posedge i_clk); while (!o_cfg_ready);
        tables.note_register(index, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item alloc_req(int bytes);
        t_in_item r;
        r.kind = KIND_ALLOC;
        r.request_size = bytes[16:0];
        r.block_address = 16'($urandom);
        return r;
    endfunction

    function automatic t_in_item free_req(int addr);
        t_in_item r;
        r.kind = KIND_FREE;
        r.request_size = 17'($urandom);
        r.block_address = addr[15:0];
        return r;
    endfunction

    // Mostly sensible allocate and free traffic, with some noise mixed in.
    function automatic t_in_item random_request();
        int roll;
        int addr;
        int top;
        t_in_item r;
        roll = $urandom_range(0, 99);
        top = (tables.pool_bytes / 6 < 1) ? 1 : tables.pool_bytes / 6;
        addr = tables.granted_start();
        if (roll < 40) begin
            r = alloc_req($urandom_range(1, top));
        end else if (roll < 75 && addr >= 0) begin
            r = free_req(addr);
        end else if (roll < 82) begin
            r = alloc_req($urandom_range(1, 8));
        end else if (roll < 88) begin
            r = alloc_req($urandom_range(0, 131071));
        end else if (roll < 94) begin
            r = free_req($urandom_range(0, 65535));
        end else begin
            r = t_in_item'($urandom);
            r.kind = 1'($urandom);
        end
        return r;
    endfunction

    // Main sequence: directed cases, then random phases over several settings.
    initial begin
        int fit_seq [8];
        int pool_seq [8];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        req_valid_held = 1'b0;
        sender_quiet = 1'b0;
        fit_seq = '{1, 0, 1, 0, 1, 0, 1, 0};
        pool_seq = '{65536, 1, 0, 131071, 200, 4096, 37, 65536};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero size, whole pool, no fit, frees good and bad, full table.
        send_request(alloc_req(0));
        send_request(alloc_req(65536));
        send_request(alloc_req(1));
        send_request(free_req(0));
        send_request(free_req(0));
        send_request(free_req(16'hFFFF));
        for (int i = 0; i < 17; i++) send_request(alloc_req(i + 1));
        send_request(free_req(1));
        send_request(alloc_req(131071));

        for (int phase = 0; phase < 8; phase++) begin
            write_register(CFG_FIT_MODE, 17'(fit_seq[phase]));
            write_register(CFG_POOL_SIZE, 17'(pool_seq[phase]));
            for (int n = 0; n < 222; n++) begin
                if (n % 60 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
                if (phase == 2 && n == 100) drain_responses();
                send_request(random_request());
            end
        end

        drain_responses();
        if (tables.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
